// ===== rtl/assert_macros.svh =====
// Assertion helpers for the linear conversion block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/lcv_pkg.sv =====
`timescale 1ns / 1ps
package lcv_pkg;

	localparam int RecipShift = 34;
	localparam int ProdW = 48;
	localparam int TermW = 44;

	typedef struct packed {
		logic signed [17:0] v;
		logic signed [5:0]  f;
	} term_t;

	typedef struct packed {
		logic [3:0] e;
		logic       force_sat;
		logic       force_neg;
	} ctl_t;

	typedef struct packed {
		logic [ProdW-1:0] prod;
		logic             neg;
		logic             div;
	} scl_t;

	function automatic logic [29:0] pow10(input logic [3:0] i);
		logic [29:0] r;
		unique case (i)
			4'd0: r = 30'd1;
			4'd1: r = 30'd10;
			4'd2: r = 30'd100;
			4'd3: r = 30'd1000;
			4'd4: r = 30'd10000;
			4'd5: r = 30'd100000;
			4'd6: r = 30'd1000000;
			4'd7: r = 30'd10000000;
			4'd8: r = 30'd100000000;
			4'd9: r = 30'd1000000000;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

	// ceil(2^34 / 10^i) for i = 1..15; i = 0 returns 0
	function automatic logic [30:0] recip10(input logic [3:0] i);
		logic [30:0] r;
		unique case (i)
			4'd1:  r = 31'd1717986919;
			4'd2:  r = 31'd171798692;
			4'd3:  r = 31'd17179870;
			4'd4:  r = 31'd1717987;
			4'd5:  r = 31'd171799;
			4'd6:  r = 31'd17180;
			4'd7:  r = 31'd1718;
			4'd8:  r = 31'd172;
			4'd9:  r = 31'd18;
			4'd10: r = 31'd2;
			4'd11, 4'd12, 4'd13, 4'd14, 4'd15: r = 31'd1;
			default: r = 31'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/lcv_decode.sv =====
`timescale 1ns / 1ps
module lcv_decode (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [7:0]    raw_reading,
	input  logic [7:0]    mult_low_byte,
	input  logic [7:0]    mult_top_byte,
	input  logic [7:0]    offset_low_byte,
	input  logic [7:0]    offset_top_byte,
	input  logic [7:0]    exponent_byte,
	output logic          out_vld,
	output lcv_pkg::term_t t1,
	output lcv_pkg::term_t t2,
	output lcv_pkg::ctl_t  ctl
);
	import lcv_pkg::*;

	logic [9:0]         m;
	logic [9:0]         b;
	logic signed [5:0]  k1;
	logic signed [5:0]  k2;
	logic signed [5:0]  e1;
	logic signed [5:0]  e2;
	logic signed [5:0]  emin;
	logic               nonneg;
	logic [3:0]         ecom;
	logic signed [18:0] p;
	term_t              t1_d;
	term_t              t2_d;
	ctl_t               ctl_d;

	always_comb begin
		m      = {mult_top_byte[7:6], mult_low_byte};
		b      = {offset_top_byte[7:6], offset_low_byte};
		k1     = {{2{exponent_byte[3]}}, exponent_byte[3:0]};
		k2     = {{2{exponent_byte[7]}}, exponent_byte[7:4]};
		e1     = k2 + 6'sd3;
		e2     = k1 + k2 + 6'sd3;
		emin   = (e1 < e2) ? e1 : e2;
		nonneg = (e1 >= 6'sd0) && (e2 >= 6'sd0);
		ecom   = nonneg ? emin[3:0] : 4'd0;
		p      = $signed(m) * $signed({1'b0, raw_reading});
		t1_d.v = p[17:0];
		t1_d.f = e1 - $signed({2'b00, ecom});
		t2_d.v = {{8{b[9]}}, b};
		t2_d.f = e2 - $signed({2'b00, ecom});
		ctl_d.e         = ecom;
		ctl_d.force_sat = (e2 > 6'sd15) && (b != 10'd0);
		ctl_d.force_neg = b[9];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		t1  <= t1_d;
		t2  <= t2_d;
		ctl <= ctl_d;
	end

endmodule

// ===== rtl/lcv_scale.sv =====
`timescale 1ns / 1ps
module lcv_scale (
	input  logic           clk,
	input  lcv_pkg::term_t term,
	output lcv_pkg::scl_t  scl
);
	import lcv_pkg::*;

	logic [17:0] absv;
	logic [16:0] mag;
	logic        div;
	logic [5:0]  nf;
	logic [3:0]  idx;
	logic [30:0] factor;
	scl_t        scl_d;

	always_comb begin
		absv   = term.v[17] ? 18'(-term.v) : term.v;
		mag    = absv[16:0];
		div    = term.f[5];
		nf     = 6'(-term.f);
		idx    = div ? nf[3:0] : term.f[3:0];
		factor = div ? recip10(idx) : {1'b0, pow10(idx)};
		scl_d.prod = ProdW'(mag) * ProdW'(factor);
		scl_d.neg  = term.v[17];
		scl_d.div  = div;
	end

	always_ff @(posedge clk) begin
		scl <= scl_d;
	end

endmodule

// ===== rtl/lcv_sum.sv =====
`timescale 1ns / 1ps
module lcv_sum (
	input  logic                clk,
	input  lcv_pkg::scl_t       a,
	input  lcv_pkg::scl_t       b,
	output logic signed [32:0]  s,
	output logic                huge
);
	import lcv_pkg::*;

	logic [TermW-1:0]   mag_a;
	logic [TermW-1:0]   mag_b;
	logic signed [44:0] ta;
	logic signed [44:0] tb;
	logic signed [45:0] sum;

	always_comb begin
		mag_a = a.div ? TermW'(a.prod[ProdW-1:RecipShift]) : a.prod[TermW-1:0];
		mag_b = b.div ? TermW'(b.prod[ProdW-1:RecipShift]) : b.prod[TermW-1:0];
		ta    = a.neg ? -$signed({1'b0, mag_a}) : $signed({1'b0, mag_a});
		tb    = b.neg ? -$signed({1'b0, mag_b}) : $signed({1'b0, mag_b});
		sum   = 46'(ta) + 46'(tb);
	end

	// keep the true sign on top so an out-of-range sum clamps the right way
	always_ff @(posedge clk) begin
		s    <= {sum[45], sum[31:0]};
		huge <= !((&sum[45:32]) || !(|sum[45:32]));
	end

endmodule

// ===== rtl/lcv_range.sv =====
`timescale 1ns / 1ps
module lcv_range (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  logic signed [32:0] s,
	input  logic               huge,
	input  lcv_pkg::ctl_t      ctl,
	output logic               out_vld,
	output logic [31:0]        value_milli,
	output logic               saturated
);
	import lcv_pkg::*;

	localparam logic signed [63:0] IntMax = 64'sh0000_0000_7fff_ffff;
	localparam logic signed [63:0] IntMin = -64'sh0000_0000_8000_0000;

	logic               vld_s4;
	logic signed [63:0] prod_s4;
	logic               sat_s4;
	logic               neg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4  <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s4  <= in_vld;
			out_vld <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		prod_s4 <= 64'(s) * $signed({34'd0, pow10(ctl.e)});
		sat_s4  <= ctl.force_sat || huge || ((ctl.e >= 4'd10) && (s != 33'sd0));
		neg_s4  <= ctl.force_sat ? ctl.force_neg : s[32];
	end

	always_ff @(posedge clk) begin
		priority if (sat_s4) begin
			value_milli <= neg_s4 ? 32'h8000_0000 : 32'h7fff_ffff;
			saturated   <= 1'b1;
		end else if (prod_s4 > IntMax) begin
			value_milli <= 32'h7fff_ffff;
			saturated   <= 1'b1;
		end else if (prod_s4 < IntMin) begin
			value_milli <= 32'h8000_0000;
			saturated   <= 1'b1;
		end else begin
			value_milli <= prod_s4[31:0];
			saturated   <= 1'b0;
		end
	end

endmodule

// ===== rtl/sensor_reading_linear_convert.sv =====
`timescale 1ns / 1ps
// Linear sensor reading converter.
// Drive the raw reading and the factor bytes and pulse start for one cycle;
// a transaction is taken at each rising edge with start high and busy low.
// busy stays low, so a new reading may be offered in every cycle.
// Each reading yields one result: valid is high for exactly one cycle with
// value_milli (signed, thousandths of the unit) and saturated on the ports.
// Throughput is one reading per cycle through the five-stage pipeline
// (decode and M*x, power-of-ten scaling of both terms, sum and overflow
// flag, common power-of-ten multiply, saturation).
// Results leave in the order the readings came in. The receiver cannot
// stall the block, so it must take each result in its valid cycle.
// Reset clears all valid bits; readings in flight are dropped and nothing
// else needs to be set up afterwards.
module sensor_reading_linear_convert (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  raw_reading,
	input  logic [7:0]  mult_low_byte,
	input  logic [7:0]  mult_top_byte,
	input  logic [7:0]  offset_low_byte,
	input  logic [7:0]  offset_top_byte,
	input  logic [7:0]  exponent_byte,
	output logic        valid,
	output logic [31:0] value_milli,
	output logic        saturated
);
	import lcv_pkg::*;

	`include "assert_macros.svh"

	logic               accept;
	logic               vld_s1;
	logic               vld_s2;
	logic               vld_s3;
	term_t              t1_s1;
	term_t              t2_s1;
	ctl_t               ctl_s1;
	ctl_t               ctl_s2;
	ctl_t               ctl_s3;
	scl_t               a_s2;
	scl_t               b_s2;
	logic signed [32:0] sum_s3;
	logic               huge_s3;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	lcv_decode u_decode (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_vld          (accept),
		.raw_reading     (raw_reading),
		.mult_low_byte   (mult_low_byte),
		.mult_top_byte   (mult_top_byte),
		.offset_low_byte (offset_low_byte),
		.offset_top_byte (offset_top_byte),
		.exponent_byte   (exponent_byte),
		.out_vld         (vld_s1),
		.t1              (t1_s1),
		.t2              (t2_s1),
		.ctl             (ctl_s1)
	);

	lcv_scale u_scale_mult (
		.clk  (clk),
		.term (t1_s1),
		.scl  (a_s2)
	);

	lcv_scale u_scale_offset (
		.clk  (clk),
		.term (t2_s1),
		.scl  (b_s2)
	);

	lcv_sum u_sum (
		.clk  (clk),
		.a    (a_s2),
		.b    (b_s2),
		.s    (sum_s3),
		.huge (huge_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s2 <= ctl_s1;
		ctl_s3 <= ctl_s2;
	end

	lcv_range u_range (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (vld_s3),
		.s           (sum_s3),
		.huge        (huge_s3),
		.ctl         (ctl_s3),
		.out_vld     (valid),
		.value_milli (value_milli),
		.saturated   (saturated)
	);

	`ASSERT_IMPL(a_result_follows_start, clk, arst_n, valid, $past(accept, 5))
	`ASSERT_IMPL(a_sat_at_limit, clk, arst_n, valid && saturated, (value_milli == 32'h7fff_ffff || value_milli == 32'h8000_0000))
	`ASSERT_IMPL(a_force_sat, clk, arst_n, vld_s1 && ctl_s1.force_sat, ##4 (valid && saturated))

endmodule
